// File: rtl/core/itoad_pkg.sv
package itoad_pkg;

    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
    localparam int MAG_W      = 31;
    localparam int CNT_W      = 5;
    localparam int REM_W      = 4;

    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_LETTER = 8'h37;
    localparam logic [7:0] ERR_CHAR     = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } itoad_state_t;

    typedef struct packed {
        logic conv_start;
        logic dig_load;
        logic dig_shift;
        logic out_load;
    } itoad_ctrl_t;

    function automatic logic [7:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [7:0] d8;
        d8 = {{(8-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(10))
            return ASCII_ZERO + d8;
        return ASCII_LETTER + d8;
    endfunction

endpackage

// File: rtl/core/itoad_bin2bcd.sv
module itoad_bin2bcd (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       hex_mode,
    input  logic [itoad_pkg::MAG_W-1:0] magnitude,
    output logic                       done,
    output logic [itoad_pkg::BCD_W-1:0] digits
);
    import itoad_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MAG_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;

    // add-3 correction per digit lane
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            else
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            cnt_next = '0;
            if (hex_mode)
            begin
                bcd_next  = {{(BCD_W-MAG_W){1'b0}}, magnitude};
                done_next = 1'b1;
            end
            else
            begin
                bcd_next  = '0;
                bin_next  = magnitude;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[MAG_W-1]};
            bin_next = {bin_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done   = done_reg;
    assign digits = bcd_reg;

endmodule

// File: rtl/core/int_to_ascii_digits.sv
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------
// input   | in_valid / in_ready  | value[31:0] signed
// output  | out_valid / out_ready| char_code[7:0], last_char, neg_error
// config  | cfg_we               | cfg_wdata (hex_mode)
//
// Decimal: shift-add-3 over ten BCD lanes; hex: the magnitude is loaded directly.
// Then SKIP drops each suppressed leading zero (up to 9) and EMIT sends each digit.
// Negative input is answered by a single error transaction, valid in the cycle after accept.
// Reset clears control state; out_ready low holds the current character.
module int_to_ascii_digits (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  char_code,
    output logic        last_char,
    output logic        neg_error
);
    import itoad_pkg::*;

    itoad_state_t       state_reg, state_next;
    itoad_ctrl_t        ctrl;
    logic               hex_mode_reg;
    logic [BCD_W-1:0]   dig_reg, dig_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;
    logic               err_reg, err_next;
    logic               conv_done;
    logic [BCD_W-1:0]   conv_digits;
    logic               out_free;
    logic               in_fire;
    logic               is_neg;
    logic [DIGIT_W-1:0] top_digit;
    logic               last_digit;

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE) && out_free;
    assign in_fire    = in_valid && in_ready;
    assign is_neg     = value[31];
    assign top_digit  = dig_reg[BCD_W-1 -: DIGIT_W];
    assign last_digit = (rem_reg == REM_W'(1));

    itoad_bin2bcd u_bin2bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.conv_start),
        .hex_mode  (hex_mode_reg),
        .magnitude (value[MAG_W-1:0]),
        .done      (conv_done),
        .digits    (conv_digits)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire && !is_neg)
                    state_next = ST_CONV;
            ST_CONV:
                if (conv_done)
                    state_next = ST_SKIP;
            ST_SKIP:
                if (top_digit != '0 || last_digit)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_free && last_digit)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.conv_start = in_fire && !is_neg;
                ctrl.out_load   = in_fire && is_neg;
            end
            ST_CONV:
                ctrl.dig_load = conv_done;
            ST_SKIP:
                ctrl.dig_shift = (top_digit == '0) && !last_digit;
            ST_EMIT:
            begin
                ctrl.out_load  = out_free;
                ctrl.dig_shift = out_free;
            end
            default:
                ctrl = '0;
        endcase
    end

    always_comb
    begin
        dig_next = dig_reg;
        rem_next = rem_reg;
        if (ctrl.dig_load)
        begin
            dig_next = conv_digits;
            rem_next = REM_W'(NUM_DIGITS);
        end
        else if (ctrl.dig_shift)
        begin
            dig_next = {dig_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            rem_next = rem_reg - REM_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
            if (state_reg == ST_IDLE)
            begin
                char_next = ERR_CHAR;
                last_next = 1'b1;
                err_next  = 1'b1;
            end
            else
            begin
                char_next = digit_to_ascii(top_digit);
                last_next = last_digit;
                err_next  = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hex_mode_reg  <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                hex_mode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;
    assign neg_error = err_reg;

`ifndef NO_ASSERTIONS
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && neg_error |-> last_char && char_code == ERR_CHAR)
        else $error("error transaction malformed");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !neg_error |->
            (char_code >= 8'h30 && char_code <= 8'h39) ||
            (char_code >= 8'h41 && char_code <= 8'h46))
        else $error("character is not a digit");

    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> state_reg == ST_CONV)
        else $error("conversion done outside CONV");

    a_emit_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT || state_reg == ST_SKIP) |-> rem_reg != '0)
        else $error("digit count underflow");
`endif

endmodule

// File: dv/tb_int_to_ascii_digits.sv
module tb_int_to_ascii_digits;

    localparam logic       RADIX_DECIMAL = 1'b0;
    localparam logic       RADIX_HEX     = 1'b1;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_ERROR      = 8'h00;
    localparam int         MAX_CHARS     = 10;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         REPORT_MAX    = 10;

    typedef struct {
        logic [7:0] code;
        logic       last;
        logic       err;
    } char_xact_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         char_code;
    logic               last_char;
    logic               neg_error;

    char_xact_t pending_chars[$];
    logic       radix_model;
    int         mismatches;
    int         quiet_cycles;
    int         rx_hold_request;
    bit         tx_gaps_on;
    bit         rx_gaps_on;

    int_to_ascii_digits u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last_char (last_char),
        .neg_error (neg_error)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // digits of one conversion, most significant first
    function automatic void expand_digits(input logic [31:0] v, input logic hex);
        logic [7:0]  digs [MAX_CHARS];
        logic [31:0] rest;
        logic [31:0] radix;
        logic [31:0] d;
        int          n;
        char_xact_t  t;
        if (v[31])
        begin
            t.code = CH_ERROR;
            t.last = 1'b1;
            t.err  = 1'b1;
            pending_chars.push_back(t);
            return;
        end
        radix = (hex == RADIX_HEX) ? 32'd16 : 32'd10;
        rest  = v;
        n     = 0;
        while (n == 0 || (rest != 0 && n < MAX_CHARS))
        begin
            d       = rest % radix;
            digs[n] = (d < 10) ? CH_ZERO + d[7:0] : CH_UPPER_A + d[7:0] - 8'd10;
            rest    = rest / radix;
            n++;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            t.code = digs[k];
            t.last = (k == 0);
            t.err  = 1'b0;
            pending_chars.push_back(t);
        end
    endfunction

    // monitor: predict on input transaction, compare on output transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (in_valid && in_ready)
                expand_digits(value, radix_model);
            if (out_valid && out_ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected transaction: code %h last %b err %b",
                                 char_code, last_char, neg_error);
                end
                else
                begin
                    char_xact_t e;
                    e = pending_chars.pop_front();
                    if (char_code !== e.code || last_char !== e.last
                        || neg_error !== e.err)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                                     e.code, e.last, e.err,
                                     char_code, last_char, neg_error);
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver
    initial
    begin
        int stall;
        int hold;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = rx_gaps_on ? $urandom_range(0, 9) : 0;
            if (rx_hold_request > 0)
            begin
                hold            = rx_hold_request;
                rx_hold_request = 0;
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_radix(input logic hex);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_wdata <= hex;
        @(posedge clk);
        radix_model = hex;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        int kind;
        int w;
        kind = $urandom_range(0, 9);
        w    = $urandom_range(1, 31);
        case (kind)
            0:       return {1'b1, 31'($urandom)};
            1:       return 32'($urandom_range(0, 20));
            2, 3:    return $urandom;
            default: return {1'b0, 31'($urandom)} & ((32'd1 << w) - 32'd1);
        endcase
    endfunction

    task automatic test_decimal_edges();
        logic [31:0] vals [$];
        vals = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd100, 32'd999999999, 32'd1000000000,
                 32'd1234567890, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000};
        set_radix(RADIX_DECIMAL);
        foreach (vals[i])
            send_value(vals[i]);
    endtask

    task automatic test_hex_edges();
        logic [31:0] vals [$];
        vals = '{32'h0, 32'h9, 32'hA, 32'hF, 32'h10, 32'h00ABCDEF, 32'h10000000,
                 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000};
        set_radix(RADIX_HEX);
        foreach (vals[i])
            send_value(vals[i]);
    endtask

    task automatic test_random_values();
        for (int p = 0; p < 6; p++)
        begin
            set_radix((p < 2) ? p[0] : logic'($urandom_range(0, 1)));
            tx_gaps_on = (p == 3) ? 1'b0 : bit'($urandom_range(0, 1));
            rx_gaps_on = (p == 3) ? 1'b0 : bit'($urandom_range(0, 1));
            repeat (16)
                send_value(rand_value());
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_output_stall();
        set_radix(RADIX_DECIMAL);
        tx_gaps_on      = 1'b0;
        rx_hold_request = 400;
        repeat (16)
            send_value(rand_value());
        tx_gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        in_valid        = 1'b0;
        value           = '0;
        radix_model     = RADIX_DECIMAL;
        mismatches      = 0;
        quiet_cycles    = 0;
        rx_hold_request = 0;
        tx_gaps_on      = 1'b1;
        rx_gaps_on      = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_decimal_edges();
        test_hex_edges();
        test_random_values();
        test_output_stall();

        quiesce();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/itoad_pkg.sv
rtl/core/itoad_bin2bcd.sv
rtl/core/int_to_ascii_digits.sv
dv/tb_int_to_ascii_digits.sv
